@@ hw/rtl/trc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trc_pkg
// Types and constants shared by the tri-state remote code transmitter and
// its port checker.
// ----------------------------------------------------------------------------
package trc_pkg;

    // Operation codes carried by an input transaction
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Frame layout
    localparam logic [3:0] FRAME_REPEATS  = 4'd8;
    localparam logic [3:0] DIGIT_COUNT    = 4'd12;
    localparam logic [3:0] LAST_TRIT      = DIGIT_COUNT - 4'd1;
    localparam logic [4:0] SYNC_GAP_UNITS = 5'd31;
    localparam logic [4:0] SYNC_HIGH_UNITS = 5'd1;

    // 3^12: the word is reduced below this once at start
    localparam logic [19:0] WORD_MODULUS = 20'd531441;

    // Trit codes
    localparam logic [1:0] TRIT_ZERO = 2'd0;
    localparam logic [1:0] TRIT_ONE  = 2'd1;
    localparam logic [1:0] TRIT_TWO  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [19:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic last_unit;
    } t_out_item;

    // Weight of the trit sent at position idx, most significant first
    function automatic logic [19:0] trit_weight(input logic [3:0] idx);
        logic [19:0] w;
        case (idx)
            4'd0:    w = 20'd177147;
            4'd1:    w = 20'd59049;
            4'd2:    w = 20'd19683;
            4'd3:    w = 20'd6561;
            4'd4:    w = 20'd2187;
            4'd5:    w = 20'd729;
            4'd6:    w = 20'd243;
            4'd7:    w = 20'd81;
            4'd8:    w = 20'd27;
            4'd9:    w = 20'd9;
            4'd10:   w = 20'd3;
            4'd11:   w = 20'd1;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

    // Length in base units of one high/low segment of a trit
    function automatic logic [4:0] seg_len(input logic [1:0] trit, input logic [1:0] seg);
        logic [4:0] len;
        case (trit)
            TRIT_ONE: len = seg[0] ? 5'd1 : 5'd3;
            TRIT_TWO: len = seg[1] ? (seg[0] ? 5'd1 : 5'd3) : (seg[0] ? 5'd3 : 5'd1);
            default:  len = seg[0] ? 5'd3 : 5'd1;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tristate_remote_code_transmitter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tri-state remote code transmitter core
// Sends a 20-bit word as 12 tri-state OOK digits, frame repeated 8 times,
// one line level per tick transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (op, data_word)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (line_level,
//          |           |                           |   busy_res, last_unit)
//
// One transaction per cycle while o_in_stall is low: each one is handled in the cycle
// it is accepted and its result is registered in the output register, or in the skid.
// Digits are extracted one at a time from a running remainder with two compares
// against the weight and its double and one subtract, so no divider is needed.
// A skid register behind the output register absorbs one result while the
// output is stalled; o_in_stall rises only while it is full.
// Synchronous active-low reset returns the block to idle with both empty.
// ----------------------------------------------------------------------------
module tristate_remote_code_transmitter_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  trc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output trc_pkg::t_out_item o_out_data
);
    import trc_pkg::*;

    // Transmission state
    logic [19:0] r_word, n_word;
    logic [19:0] r_rem, n_rem;
    logic [3:0]  r_trit_index, n_trit_index;
    logic [1:0]  r_segment_index, n_segment_index;
    logic [4:0]  r_unit_count, n_unit_count;
    logic [2:0]  r_repeat_count, n_repeat_count;
    logic        r_in_sync, n_in_sync;
    logic        r_sending, n_sending;

    // Output register and skid
    logic        r_out_valid;
    t_out_item   r_out;
    logic        r_skid_valid;
    t_out_item   r_skid;

    logic        accept;
    logic        out_free;
    t_out_item   res;
    logic [19:0] word_mod;
    logic [19:0] weight;
    logic [20:0] weight_x2;
    logic [1:0]  trit;
    logic [19:0] trit_sub;
    logic [4:0]  len;
    logic        unit_done;

    assign accept   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    assign word_mod  = (i_in_data.data_word >= WORD_MODULUS) ?
                       (i_in_data.data_word - WORD_MODULUS) : i_in_data.data_word;
    assign weight    = trit_weight(r_trit_index);
    assign weight_x2 = {weight, 1'b0};

    always_comb begin
        if ({1'b0, r_rem} >= weight_x2) begin
            trit     = TRIT_TWO;
            trit_sub = weight_x2[19:0];
        end else if (r_rem >= weight) begin
            trit     = TRIT_ONE;
            trit_sub = weight;
        end else begin
            trit     = TRIT_ZERO;
            trit_sub = 20'd0;
        end
    end

    assign len = r_in_sync ? ((r_segment_index == 2'd0) ? SYNC_HIGH_UNITS : SYNC_GAP_UNITS)
                           : seg_len(trit, r_segment_index);
    assign unit_done = ({1'b0, r_unit_count} + 6'd1) >= {1'b0, len};

    always_comb begin
        n_word          = r_word;
        n_rem           = r_rem;
        n_trit_index    = r_trit_index;
        n_segment_index = r_segment_index;
        n_unit_count    = r_unit_count;
        n_repeat_count  = r_repeat_count;
        n_in_sync       = r_in_sync;
        n_sending       = r_sending;
        res             = '0;
        if (accept) begin
            if (i_in_data.op == OP_START) begin
                // ignore a start while a transmission runs
                if (!r_sending) begin
                    n_word          = word_mod;
                    n_rem           = word_mod;
                    n_trit_index    = 4'd0;
                    n_segment_index = 2'd0;
                    n_unit_count    = 5'd0;
                    n_repeat_count  = 3'd0;
                    n_in_sync       = 1'b0;
                    n_sending       = 1'b1;
                end
                res.busy_res = 1'b1;
            end else begin
                res.busy_res = r_sending;
                if (r_sending) begin
                    res.line_level = ~r_segment_index[0];
                    if (unit_done) begin
                        n_unit_count = 5'd0;
                        if (!r_in_sync) begin
                            if (r_segment_index == 2'd3) begin
                                n_segment_index = 2'd0;
                                n_rem           = r_rem - trit_sub;
                                if (r_trit_index == LAST_TRIT) begin
                                    // reload the word for the next frame
                                    n_trit_index = 4'd0;
                                    n_in_sync    = 1'b1;
                                    n_rem        = r_word;
                                end else begin
                                    n_trit_index = r_trit_index + 4'd1;
                                end
                            end else begin
                                n_segment_index = r_segment_index + 2'd1;
                            end
                        end else if (r_segment_index == 2'd0) begin
                            n_segment_index = 2'd1;
                        end else begin
                            n_segment_index = 2'd0;
                            n_in_sync       = 1'b0;
                            if (({1'b0, r_repeat_count} + 4'd1) >= FRAME_REPEATS) begin
                                n_repeat_count = 3'd0;
                                n_sending      = 1'b0;
                                res.last_unit  = 1'b1;
                            end else begin
                                n_repeat_count = r_repeat_count + 3'd1;
                            end
                        end
                    end else begin
                        n_unit_count = r_unit_count + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trit_index    <= 4'd0;
            r_segment_index <= 2'd0;
            r_unit_count    <= 5'd0;
            r_repeat_count  <= 3'd0;
            r_in_sync       <= 1'b0;
            r_sending       <= 1'b0;
        end else begin
            r_trit_index    <= n_trit_index;
            r_segment_index <= n_segment_index;
            r_unit_count    <= n_unit_count;
            r_repeat_count  <= n_repeat_count;
            r_in_sync       <= n_in_sync;
            r_sending       <= n_sending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_rem  <= n_rem;
    end

    // Output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ hw/rtl/trc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trc_checker
// Port-level checks for the tri-state remote code transmitter core.
// ----------------------------------------------------------------------------
module trc_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_stall,
    input trc_pkg::t_in_item  i_in_data,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input trc_pkg::t_out_item o_out_data
);
    import trc_pkg::*;

    // Reset empties both the output register and the skid
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("output or skid not empty after reset");

    // Input stall only follows a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // Every accepted transaction leaves a result waiting
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Carrier and the final unit only occur during a transmission
    a_level_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.line_level || o_out_data.last_unit))
            |-> o_out_data.busy_res)
        else $error("line activity while not busy");

endmodule

bind tristate_remote_code_transmitter_core trc_checker u_trc_checker (.*);
`default_nettype wire

@@ tb/sv/trc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tri-state remote code transmitter result checker
// Watches both channels of the transmitter core. It runs its own model of
// the digit/segment/sync sequencer on every accepted input transaction and
// compares each accepted output transaction, field by field, with the oldest
// predicted line level. It reports a failure count and the number of
// predictions still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module trc_result_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_stall,
    input  trc_pkg::t_in_item  i_in_data,
    input  wire                i_out_valid,
    input  wire                i_out_stall,
    input  trc_pkg::t_out_item i_out_data,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_checked
);
    import trc_pkg::*;

    localparam int LINE_CAP = 40;

    t_out_item  predicted_levels[$];

    // Sequencer copy: digits in send order, most significant first
    logic [1:0] trits [0:DIGIT_COUNT-1];
    logic [3:0] trit_pos;
    logic [1:0] seg_pos;
    logic [4:0] units_spent;
    logic [2:0] frame_no;
    logic       in_sync;
    logic       active;

    task automatic report_mismatch(input string what, input logic [2:0] want,
                                   input logic [2:0] got);
        // Keep the log short on a badly broken core, but count everything
        if (o_mismatches < LINE_CAP) begin
            $display("[%0t] result %0d: %s: expected %b got %b",
                     $time, o_checked, what, want, got);
        end
        o_mismatches++;
    endtask

    // Units spent in one high/low segment of a digit
    function automatic int unit_span(input logic [1:0] trit, input logic [1:0] seg);
        case (trit)
            TRIT_ONE: return seg[0] ? 1 : 3;
            TRIT_TWO: return (seg == 2'd0 || seg == 2'd3) ? 1 : 3;
            default:  return seg[0] ? 3 : 1;
        endcase
    endfunction

    task automatic load_trits(input logic [19:0] word);
        int unsigned rem;
        rem = 32'(word);
        // Least significant digit lands in the last slot; excess digits drop
        for (int k = int'(DIGIT_COUNT) - 1; k >= 0; k--) begin
            trits[k] = 2'(rem % 3);
            rem = rem / 3;
        end
    endtask

    task automatic predict_level(input t_in_item item, output t_out_item res);
        int span;
        res = '0;
        if (item.op == OP_START) begin
            // Drop a start that arrives while a transmission runs
            if (!active) begin
                load_trits(item.data_word);
                trit_pos    = '0;
                seg_pos     = '0;
                units_spent = '0;
                frame_no    = '0;
                in_sync     = 1'b0;
                active      = 1'b1;
            end
            res.busy_res = active;
        end else if (active) begin
            res.busy_res   = 1'b1;
            res.line_level = ~seg_pos[0];
            if (in_sync) begin
                span = (seg_pos == 2'd0) ? int'(SYNC_HIGH_UNITS) : int'(SYNC_GAP_UNITS);
            end else begin
                span = unit_span(trits[trit_pos], seg_pos);
            end
            if (int'(units_spent) + 1 < span) begin
                units_spent = units_spent + 5'd1;
            end else begin
                units_spent = '0;
                if (!in_sync) begin
                    if (seg_pos == 2'd3) begin
                        seg_pos = '0;
                        if (trit_pos == DIGIT_COUNT - 4'd1) begin
                            trit_pos = '0;
                            in_sync  = 1'b1;
                        end else begin
                            trit_pos = trit_pos + 4'd1;
                        end
                    end else begin
                        seg_pos = seg_pos + 2'd1;
                    end
                end else if (seg_pos == 2'd0) begin
                    seg_pos = 2'd1;
                end else begin
                    // End of frame: repeat or finish the transmission
                    seg_pos = '0;
                    in_sync = 1'b0;
                    if (int'(frame_no) + 1 >= int'(FRAME_REPEATS)) begin
                        frame_no       = '0;
                        active         = 1'b0;
                        res.last_unit  = 1'b1;
                    end else begin
                        frame_no = frame_no + 3'd1;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item fresh;
        if (!i_rst_n) begin
            predicted_levels.delete();
            for (int k = 0; k < int'(DIGIT_COUNT); k++) trits[k] = TRIT_ZERO;
            trit_pos      = '0;
            seg_pos       = '0;
            units_spent   = '0;
            frame_no      = '0;
            in_sync       = 1'b0;
            active        = 1'b0;
            o_mismatches  = 0;
            o_outstanding = 0;
            o_checked     = 0;
        end else begin
            // A result always leaves after its input was accepted, so pop before push
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (predicted_levels.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 3'b000, i_out_data);
                end else begin
                    want = predicted_levels.pop_front();
                    if (i_out_data.line_level !== want.line_level)
                        report_mismatch("line_level", 3'(want.line_level),
                                        3'(i_out_data.line_level));
                    if (i_out_data.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 3'(want.busy_res),
                                        3'(i_out_data.busy_res));
                    if (i_out_data.last_unit !== want.last_unit)
                        report_mismatch("last_unit", 3'(want.last_unit),
                                        3'(i_out_data.last_unit));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_level(i_in_data, fresh);
                predicted_levels.push_back(fresh);
            end
            o_outstanding = predicted_levels.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tri-state remote code transmitter testbench
// Drives start and tick transactions into the core in random bursts while the
// output side stalls on its own pattern, including one long hold that backs
// the core up. A few directed transactions cover idle ticks, the widest word
// and starts while busy; random starts and ticks then follow until about
// ITEM_TARGET transactions have gone into a transmission. The result checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import trc_pkg::*;

    localparam int UNITS_PER_TRIT = 8;
    localparam int TX_TICKS       = int'(FRAME_REPEATS) * (int'(DIGIT_COUNT) * UNITS_PER_TRIT
                                    + int'(SYNC_HIGH_UNITS) + int'(SYNC_GAP_UNITS));
    localparam int ITEM_TARGET    = 500;
    localparam int LONG_HOLD      = 300;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    int mismatches;
    int outstanding;
    int checked;

    int ticks_left;
    int tx_done;
    int starts_dropped;
    int useful_items;
    int sent_total;

    tristate_remote_code_transmitter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    trc_result_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [19:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 20'd0;
            1: return 20'hFFFFF;
            // just below, at and just above 3^12
            2: return WORD_MODULUS - 20'd1 + 20'($urandom_range(0, 2));
            3, 4: return 20'($urandom_range(0, 531440));
            default: return 20'($urandom);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_item(input logic op, input logic [19:0] word);
        @(negedge i_clk);
        i_in_valid          = 1'b1;
        i_in_data.op        = op;
        i_in_data.data_word = word;
        do @(posedge i_clk); while (o_in_stall);
        sent_total++;
        if (op == OP_START) begin
            if (ticks_left == 0) begin
                ticks_left = TX_TICKS;
                useful_items++;
            end else begin
                starts_dropped++;
            end
        end else if (ticks_left != 0) begin
            ticks_left--;
            useful_items++;
            if (ticks_left == 0) tx_done++;
        end
    endtask

    task automatic hold_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    initial begin : stimulus
        int  burst;
        logic op;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        ticks_left     = 0;
        tx_done        = 0;
        starts_dropped = 0;
        useful_items   = 0;
        sent_total     = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Idle ticks, widest word (reduced modulo 3^12), starts while busy
        send_item(OP_TICK, 20'h00000);
        send_item(OP_TICK, 20'hFFFFF);
        send_item(OP_START, 20'hFFFFF);
        send_item(OP_START, 20'h00000);
        send_item(OP_START, 20'd531440);
        repeat (18) send_item(OP_TICK, 20'($urandom));

        // Random words; stray starts and idle ticks
        while (useful_items < ITEM_TARGET) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (ticks_left != 0) op = ($urandom_range(0, 24) == 0) ? OP_START : OP_TICK;
                else op = ($urandom_range(0, 9) < 6) ? OP_START : OP_TICK;
                send_item(op, (op == OP_START) ? pick_word() : 20'($urandom));
            end
            if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 8));
        end
        hold_input(1);

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transactions: %0d full transmissions, %0d starts dropped",
                 sent_total, tx_done, starts_dropped);
        $display("compared %0d results with the predicted line levels", checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : receiver
        int  mode;
        int  span;
        int  elapsed;
        logic held_off;
        i_out_stall = 1'b0;
        elapsed     = 0;
        held_off    = 1'b0;
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 9) < 4);
                    2:       i_out_stall = ($urandom_range(0, 9) < 8);
                    default: i_out_stall = ~i_out_stall;
                endcase
            end
            elapsed += span;
            // Hold off once for a long stretch so the core backs up its input
            if (!held_off && elapsed >= 150) begin
                held_off = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("no transaction for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
